// ----- hw/rtl/lsm_pkg.sv -----
package lsm_pkg;

  localparam int unsigned LSM_WIDTH = 64;

  typedef enum logic [3:0] {
    SRC_UH,
    SRC_VL,
    SRC_VH,
    SRC_QL,
    SRC_QH,
    SRC_T,
    SRC_P,
    SRC_Q,
    SRC_ONE
  } src_e;

  typedef enum logic [2:0] {
    SUB_NONE,
    SUB_T,
    SUB_QL,
    SUB_QL2,
    SUB_QH2
  } sub_e;

  typedef struct packed {
    src_e a;
    src_e b;
    src_e dst;
    sub_e sub;
  } uop_t;

endpackage

// ----- hw/rtl/lsm_mulmod.sv -----
module lsm_mulmod import lsm_pkg::*; #(
  parameter int unsigned WIDTH = LSM_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  function automatic logic [WIDTH-1:0] add_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                               logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] gap;
    gap = n - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] acc_d;

  assign dbl   = add_mod(acc_q, acc_q, n_q);
  assign acc_d = b_q[WIDTH-1] ? add_mod(dbl, a_q, n_q) : dbl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      n_q   <= n_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != CW'(1) |=> busy_q)
    else $error("multiplier stopped early");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("done without work");

endmodule

// ----- hw/rtl/lucas_sequence_mod_n_unit.sv -----
// channel | valid     | stall      | payload
// in      | in_valid_i| in_stall_o | param_p_i, param_q_i, index_k_i, modulus_i
// out     | out_valid_o| out_stall_i| u_value_o, v_value_o, q_power_o, bad_modulus_o
// One item at a time; each modular multiply runs in the shared shift-and-add
// unit, plus an index scan that finds the top set bit of k. Zero modulus,
// modulus one or zero index skip straight to the done state. Reset clears
// control state only. A stalled result holds the sequencer in its last state;
// input stall is high whenever an item is in work.
module lucas_sequence_mod_n_unit import lsm_pkg::*; #(
  parameter int unsigned WIDTH = LSM_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [WIDTH-1:0] param_p_i,
  input  logic signed [WIDTH-1:0] param_q_i,
  input  logic [WIDTH-1:0]        index_k_i,
  input  logic [WIDTH-1:0]        modulus_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [WIDTH-1:0]        u_value_o,
  output logic [WIDTH-1:0]        v_value_o,
  output logic [WIDTH-1:0]        q_power_o,
  output logic                    bad_modulus_o
);

  localparam int unsigned JW = $clog2(WIDTH);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REDP   = 8'b0000_0010,
    ST_REDQ   = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_LADDER = 8'b0001_0000,
    ST_FINAL  = 8'b0010_0000,
    ST_TRAIL  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  function automatic logic [WIDTH-1:0] add_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                               logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] gap;
    gap = n - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  function automatic logic [WIDTH-1:0] sub_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                               logic [WIDTH-1:0] n);
    return (x >= y) ? x - y : x + (n - y);
  endfunction

  function automatic uop_t get_uop(state_e st, logic [2:0] step, logic bit_v);
    uop_t u;
    u = '{a: SRC_ONE, b: SRC_P, dst: SRC_P, sub: SUB_NONE};
    unique case (st)
      ST_REDQ: u = '{a: SRC_ONE, b: SRC_Q, dst: SRC_Q, sub: SUB_NONE};
      ST_LADDER: begin
        unique case (step)
          3'd0: u = '{a: SRC_QL, b: SRC_QH, dst: SRC_QL, sub: SUB_NONE};
          3'd1: u = '{a: SRC_QL, b: SRC_P, dst: SRC_T, sub: SUB_NONE};
          3'd2: u = bit_v ? '{a: SRC_QL, b: SRC_Q, dst: SRC_QH, sub: SUB_NONE}
                          : '{a: SRC_QL, b: SRC_ONE, dst: SRC_QH, sub: SUB_NONE};
          3'd3: u = bit_v ? '{a: SRC_UH, b: SRC_VH, dst: SRC_UH, sub: SUB_NONE}
                          : '{a: SRC_UH, b: SRC_VL, dst: SRC_UH, sub: SUB_QL};
          3'd4: u = bit_v ? '{a: SRC_VL, b: SRC_VH, dst: SRC_VL, sub: SUB_T}
                          : '{a: SRC_VH, b: SRC_VL, dst: SRC_VH, sub: SUB_T};
          default: u = bit_v ? '{a: SRC_VH, b: SRC_VH, dst: SRC_VH, sub: SUB_QH2}
                             : '{a: SRC_VL, b: SRC_VL, dst: SRC_VL, sub: SUB_QL2};
        endcase
      end
      ST_FINAL: begin
        unique case (step)
          3'd0: u = '{a: SRC_QL, b: SRC_QH, dst: SRC_QL, sub: SUB_NONE};
          3'd1: u = '{a: SRC_QL, b: SRC_Q, dst: SRC_QH, sub: SUB_NONE};
          3'd2: u = '{a: SRC_UH, b: SRC_VL, dst: SRC_UH, sub: SUB_QL};
          3'd3: u = '{a: SRC_QL, b: SRC_P, dst: SRC_T, sub: SUB_NONE};
          3'd4: u = '{a: SRC_VL, b: SRC_VH, dst: SRC_VL, sub: SUB_T};
          default: u = '{a: SRC_QL, b: SRC_QH, dst: SRC_QL, sub: SUB_NONE};
        endcase
      end
      ST_TRAIL: begin
        unique case (step)
          3'd0: u = '{a: SRC_UH, b: SRC_VL, dst: SRC_UH, sub: SUB_NONE};
          3'd1: u = '{a: SRC_VL, b: SRC_VL, dst: SRC_VL, sub: SUB_QL2};
          default: u = '{a: SRC_QL, b: SRC_QL, dst: SRC_QL, sub: SUB_NONE};
        endcase
      end
      default: u = '{a: SRC_ONE, b: SRC_P, dst: SRC_P, sub: SUB_NONE};
    endcase
    return u;
  endfunction

  state_e           state_q;
  logic             wait_q;
  logic [2:0]       step_q;
  logic [JW-1:0]    j_q;
  logic [WIDTH-1:0] kr_q;
  logic             p_neg_q, q_neg_q, bad_q;
  logic [WIDTH-1:0] n_q, uh_q, vl_q, vh_q, ql_q, qh_q, t_q, p_q, q_q;
  logic             out_valid_q, out_bad_q;
  logic [WIDTH-1:0] out_u_q, out_v_q, out_q_q;

  uop_t             uop;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] op_a, op_b, mul_res, sub_term, wb_val;
  logic             compute, last_step, neg_fix;
  logic [WIDTH-1:0] p_in, q_in;

  assign p_in = param_p_i;
  assign q_in = param_q_i;

  assign compute = (state_q == ST_REDP) || (state_q == ST_REDQ) || (state_q == ST_LADDER)
                || (state_q == ST_FINAL) || (state_q == ST_TRAIL);
  assign uop = get_uop(state_q, step_q, kr_q[WIDTH-1]);

  function automatic logic [WIDTH-1:0] pick(src_e s, logic [WIDTH-1:0] uh, logic [WIDTH-1:0] vl,
      logic [WIDTH-1:0] vh, logic [WIDTH-1:0] ql, logic [WIDTH-1:0] qh, logic [WIDTH-1:0] t,
      logic [WIDTH-1:0] p, logic [WIDTH-1:0] q);
    logic [WIDTH-1:0] r;
    unique case (s)
      SRC_UH:  r = uh;
      SRC_VL:  r = vl;
      SRC_VH:  r = vh;
      SRC_QL:  r = ql;
      SRC_QH:  r = qh;
      SRC_T:   r = t;
      SRC_P:   r = p;
      SRC_Q:   r = q;
      default: r = WIDTH'(1);
    endcase
    return r;
  endfunction

  assign op_a = pick(uop.a, uh_q, vl_q, vh_q, ql_q, qh_q, t_q, p_q, q_q);
  assign op_b = pick(uop.b, uh_q, vl_q, vh_q, ql_q, qh_q, t_q, p_q, q_q);

  always_comb begin
    unique case (uop.sub)
      SUB_T:   sub_term = t_q;
      SUB_QL:  sub_term = ql_q;
      SUB_QL2: sub_term = add_mod(ql_q, ql_q, n_q);
      SUB_QH2: sub_term = add_mod(qh_q, qh_q, n_q);
      default: sub_term = '0;
    endcase
  end

  assign neg_fix = ((state_q == ST_REDP) && p_neg_q) || ((state_q == ST_REDQ) && q_neg_q);
  assign wb_val  = neg_fix ? sub_mod('0, mul_res, n_q) : sub_mod(mul_res, sub_term, n_q);
  assign mul_start = compute && !wait_q;

  always_comb begin
    unique case (state_q)
      ST_LADDER, ST_FINAL: last_step = (step_q == 3'd5);
      ST_TRAIL:            last_step = (step_q == 3'd2);
      default:             last_step = 1'b1;
    endcase
  end

  lsm_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .n_i     (n_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= 1'b0;
      step_q      <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q <= '0;
            wait_q <= 1'b0;
            j_q    <= JW'(WIDTH - 1);
            if (modulus_i == '0 || modulus_i == WIDTH'(1) || index_k_i == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_REDP;
            end
          end
        end
        ST_SCAN: begin
          if (kr_q[WIDTH-1]) begin
            state_q <= (kr_q[WIDTH-2:0] != '0) ? ST_LADDER : ST_FINAL;
          end else begin
            j_q <= j_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          if (mul_start) begin
            wait_q <= 1'b1;
          end else if (mul_done) begin
            wait_q <= 1'b0;
            step_q <= last_step ? 3'd0 : step_q + 3'd1;
            if (last_step) begin
              priority case (state_q)
                ST_REDP: state_q <= ST_REDQ;
                ST_REDQ: state_q <= ST_SCAN;
                ST_LADDER: begin
                  j_q <= j_q - 1'b1;
                  if (kr_q[WIDTH-3:0] == '0) begin
                    state_q <= ST_FINAL;
                  end
                end
                ST_FINAL: state_q <= (j_q != '0) ? ST_TRAIL : ST_DONE;
                default: begin
                  j_q <= j_q - 1'b1;
                  if (j_q == JW'(1)) begin
                    state_q <= ST_DONE;
                  end
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      n_q     <= modulus_i;
      kr_q    <= index_k_i;
      p_neg_q <= p_in[WIDTH-1];
      q_neg_q <= q_in[WIDTH-1];
      p_q     <= p_in[WIDTH-1] ? -p_in : p_in;
      q_q     <= q_in[WIDTH-1] ? -q_in : q_in;
      bad_q   <= (modulus_i == '0);
      uh_q    <= (modulus_i == '0 || modulus_i == WIDTH'(1) || index_k_i == '0)
                 ? '0 : WIDTH'(1);
      vl_q    <= (modulus_i == '0 || modulus_i == WIDTH'(1) || modulus_i == WIDTH'(2))
                 ? '0 : WIDTH'(2);
      ql_q    <= (modulus_i == '0 || modulus_i == WIDTH'(1)) ? '0 : WIDTH'(1);
      qh_q    <= WIDTH'(1);
    end else if (state_q == ST_SCAN && !kr_q[WIDTH-1]) begin
      kr_q <= kr_q << 1;
    end else if (compute && mul_done && !mul_start) begin
      unique case (uop.dst)
        SRC_UH:  uh_q <= wb_val;
        SRC_VL:  vl_q <= wb_val;
        SRC_VH:  vh_q <= wb_val;
        SRC_QL:  ql_q <= wb_val;
        SRC_QH:  qh_q <= wb_val;
        SRC_T:   t_q  <= wb_val;
        SRC_P: begin
          p_q  <= wb_val;
          vh_q <= wb_val;
        end
        default: q_q <= wb_val;
      endcase
      if (state_q == ST_LADDER && last_step) begin
        kr_q <= kr_q << 1;
      end
    end
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_u_q   <= uh_q;
      out_v_q   <= vl_q;
      out_q_q   <= ql_q;
      out_bad_q <= bad_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign u_value_o     = out_u_q;
  assign v_value_o     = out_v_q;
  assign q_power_o     = out_q_q;
  assign bad_modulus_o = out_bad_q;

  a_start_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> compute)
    else $error("multiply issued outside a compute state");
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> wait_q)
    else $error("multiply result with nothing pending");
  a_trail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TRAIL |-> j_q != '0)
    else $error("trailing pass with no zero bits left");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> u_value_o == '0 && v_value_o == '0 && q_power_o == '0)
    else $error("error result carries data");

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsm_pkg::*;

  localparam int W = LSM_WIDTH;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [W-1:0] p;
    logic [W-1:0] q;
    logic [W-1:0] k;
    logic [W-1:0] n;
  } lucas_req_t;

  typedef struct packed {
    logic [W-1:0] u;
    logic [W-1:0] v;
    logic [W-1:0] qk;
    logic         bad;
  } lucas_res_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [W-1:0] param_p_i = '0;
  logic signed [W-1:0] param_q_i = '0;
  logic [W-1:0] index_k_i = '0;
  logic [W-1:0] modulus_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [W-1:0] u_value_o, v_value_o, q_power_o;
  logic bad_modulus_o;

  lucas_req_t pending_reqs[$];
  lucas_res_t expected_res[$];
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  bit in_fire = 0;

  lucas_sequence_mod_n_unit #(.WIDTH(W)) u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] n);
    logic [W-1:0] gap;
    gap = n - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic logic [W-1:0] sub_m(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] n);
    return (a >= b) ? a - b : a + (n - b);
  endfunction

  function automatic logic [W-1:0] mul_m(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] n);
    logic [W-1:0] acc;
    acc = '0;
    for (int i = W - 1; i >= 0; i--) begin
      acc = add_m(acc, acc, n);
      if (b[i]) acc = add_m(acc, a, n);
    end
    return acc;
  endfunction

  function automatic logic [W-1:0] fold_signed(logic [W-1:0] raw, logic [W-1:0] n);
    logic [W-1:0] r;
    if (!raw[W-1]) return raw % n;
    r = (-raw) % n;
    return (r == 0) ? '0 : n - r;
  endfunction

  function automatic lucas_res_t lucas_uv(lucas_req_t rq);
    lucas_res_t rs;
    logic [W-1:0] n, k, p, q, uh, vl, vh, ql, qh, t;
    int top, tz;
    n = rq.n;
    k = rq.k;
    rs = '0;
    if (n == 0) begin
      rs.bad = 1;
      return rs;
    end
    if (n == 1) return rs;
    if (k == 0) begin
      rs.v = 2 % n;
      rs.qk = 1;
      return rs;
    end
    p = fold_signed(rq.p, n);
    q = fold_signed(rq.q, n);
    top = W - 1;
    while (!k[top]) top--;
    tz = 0;
    while (!k[tz]) tz++;
    uh = 1;
    vl = 2 % n;
    vh = p;
    ql = 1;
    qh = 1;
    for (int j = top; j > tz; j--) begin
      ql = mul_m(ql, qh, n);
      t = mul_m(ql, p, n);
      if (k[j]) begin
        qh = mul_m(ql, q, n);
        uh = mul_m(uh, vh, n);
        vl = sub_m(mul_m(vl, vh, n), t, n);
        vh = sub_m(mul_m(vh, vh, n), add_m(qh, qh, n), n);
      end else begin
        qh = ql;
        uh = sub_m(mul_m(uh, vl, n), ql, n);
        vh = sub_m(mul_m(vh, vl, n), t, n);
        vl = sub_m(mul_m(vl, vl, n), add_m(ql, ql, n), n);
      end
    end
    ql = mul_m(ql, qh, n);
    qh = mul_m(ql, q, n);
    uh = sub_m(mul_m(uh, vl, n), ql, n);
    t = mul_m(ql, p, n);
    vl = sub_m(mul_m(vl, vh, n), t, n);
    ql = mul_m(ql, qh, n);
    for (int j = 0; j < tz; j++) begin
      uh = mul_m(uh, vl, n);
      vl = sub_m(mul_m(vl, vl, n), add_m(ql, ql, n), n);
      ql = mul_m(ql, ql, n);
    end
    rs.u = uh;
    rs.v = vl;
    rs.qk = ql;
    return rs;
  endfunction

  function automatic logic [W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [W-1:0] rand_k();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return rand_word();
      2: return rand_word() >> $urandom_range(0, W - 1);
      3: return rand_word() << $urandom_range(0, W - 1);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [W-1:0] rand_n();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2);
      1: return rand_word() | (64'h1 << (W - 1));
      2: return {W{1'b1}};
      3: return $urandom_range(3, 100);
      4: return rand_word() >> $urandom_range(0, W - 1);
      default: return rand_word();
    endcase
  endfunction

  task automatic push_req(logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] k, logic [W-1:0] n);
    pending_reqs.push_back('{p: p, q: q, k: k, n: n});
  endtask

  initial begin
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONES = {W{1'b1}};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    push_req(3, 5, 10, 0);
    push_req(SMIN, ONES, ONES, 0);
    push_req(7, -2, 99, 1);
    push_req(SMAX, SMIN, 0, 1000);
    push_req(1, -1, 0, 2);
    push_req(1, -1, 1, 1000);
    push_req(1, -1, 2, 1000);
    push_req(1, -1, 90, ONES);
    push_req(SMAX, SMIN, ONES, ONES);
    push_req(SMIN, SMAX, ONES, SMIN);
    push_req(ONES, ONES, 64'h8000_0000_0000_0000, ONES - 58);
    push_req(2, 1, 37, 97);
    push_req(4, 4, 16, 1024);
    push_req(-5, 3, 12345, 2);
    push_req(3, 1, ONES, 3);
    push_req(0, 0, 7, 13);
    push_req(6, 9, 5, 11);
    wait (pending_reqs.size() == 0 && expected_res.size() == 0);
    hold_off = 1;
    repeat (20) @(posedge clk_i);
    hold_off = 0;
    for (int i = 0; i < 100; i++) begin
      push_req(rand_word() >> $urandom_range(0, W - 1) ^ ($urandom_range(0, 1) ? ONES : 0),
               rand_word(), rand_k(), rand_n());
      if (i == 50) begin
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
      end
    end
    wait (pending_reqs.size() == 0);
    stim_done = 1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        in_valid_i <= 0;
      end else if (!in_valid_i) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (!hold_off && pending_reqs.size() > 0) begin
          lucas_req_t rq;
          rq = pending_reqs.pop_front();
          expected_res.push_back(lucas_uv(rq));
          param_p_i <= rq.p;
          param_q_i <= rq.q;
          index_k_i <= rq.k;
          modulus_i <= rq.n;
          in_valid_i <= 1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 4);
            gap_left <= $urandom_range(0, 300);
          end
        end
      end
      out_stall_i <= ((cycles / 500) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result u=%h v=%h q=%h", u_value_o, v_value_o, q_power_o);
        errors++;
      end else begin
        lucas_res_t ex;
        ex = expected_res.pop_front();
        if (u_value_o !== ex.u) begin
          $error("u_value exp %h got %h", ex.u, u_value_o);
          errors++;
        end
        if (v_value_o !== ex.v) begin
          $error("v_value exp %h got %h", ex.v, v_value_o);
          errors++;
        end
        if (q_power_o !== ex.qk) begin
          $error("q_power exp %h got %h", ex.qk, q_power_o);
          errors++;
        end
        if (bad_modulus_o !== ex.bad) begin
          $error("bad_modulus exp %b got %b", ex.bad, bad_modulus_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && !in_valid_i && expected_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
